FILE: rtl/lbev_pkg.sv
// Package for the lidar bird's-eye height rasterizer.
// Sizes, operation and register codes, controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbev_pkg;

  localparam int MAX_SIDE = 512;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam int POS_W  = 24;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 9;
  localparam int PIX_W  = 8;
  localparam int CELL_W = 21;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_POINT = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_COS    = 3'd0,
    CFG_SIN    = 3'd1,
    CFG_RADIUS = 3'd2,
    CFG_CPM    = 3'd3,
    CFG_HLOW   = 3'd4,
    CFG_HHIGH  = 3'd5,
    CFG_SMAX   = 3'd6,
    CFG_SMIN   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic mul1;
    logic mul2;
    logic check;
    logic div_step;
    logic wr;
    logic rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic shade_direct;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/lbev_if.sv
// Stream interfaces for the rasterizer: point/operation beats in, result beats out.
// Depends on lbev_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lbev_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          operation;
  logic signed [lbev_pkg::POS_W-1:0]   pos_x;
  logic signed [lbev_pkg::POS_W-1:0]   pos_y;
  logic signed [lbev_pkg::POS_W-1:0]   pos_z;
  logic [lbev_pkg::IDX_W-1:0]          read_row;
  logic [lbev_pkg::IDX_W-1:0]          read_col;

  modport source (output valid, operation, pos_x, pos_y, pos_z, read_row, read_col,
                  input ready);
  modport sink   (input valid, operation, pos_x, pos_y, pos_z, read_row, read_col,
                  output ready);
endinterface

interface lbev_out_if;
  logic                         valid;
  logic                         ready;
  logic                         pixel_written;
  logic [lbev_pkg::IDX_W-1:0]   out_row;
  logic [lbev_pkg::IDX_W-1:0]   out_col;
  logic [lbev_pkg::PIX_W-1:0]   pixel_value;

  modport source (output valid, pixel_written, out_row, out_col, pixel_value,
                  input ready);
  modport sink   (input valid, pixel_written, out_row, out_col, pixel_value,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/lbev_ctrl.sv
// Controller FSM of the rasterizer: sequences clear sweep, projection, divide,
// pixel write, read and result hand-off. Depends on lbev_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbev_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     in_op_i,
  output logic                in_ready_o,
  input  wire lbev_pkg::sts_t sts_i,
  output lbev_pkg::cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MUL1  = 10'b0000000100,
    S_MUL2  = 10'b0000001000,
    S_CHECK = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_WRITE = 10'b0001000000,
    S_READ  = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_e;

  state_e     state_q, state_d;
  logic       pend_q, pend_d;   // clear sweep owes a result beat
  logic [2:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = pend_q ? S_DONE : S_IDLE;
          pend_d  = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (in_op_i)
            lbev_pkg::OP_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              pend_d          = 1'b1;
              state_d         = S_CLEAR;
            end
            lbev_pkg::OP_POINT: state_d = S_MUL1;
            lbev_pkg::OP_READ:  state_d = S_READ;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        cnt_d       = '0;
        state_d     = S_DIV;
      end
      S_DIV: begin
        if (!sts_i.hit) begin
          state_d = S_DONE;
        end else if (sts_i.shade_direct) begin
          state_d = S_WRITE;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 3'd1;
          if (cnt_q == 3'd7) state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = S_DONE;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

  a_point_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && in_op_i == lbev_pkg::OP_POINT) |=> state_q == S_MUL1)
    else $error("point beat did not start projection");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over a waiting beat");

endmodule

`default_nettype wire

FILE: rtl/lbev_dp.sv
// Datapath of the rasterizer: config registers, projection multipliers, shade
// divider, image memory and result register. Depends on lbev_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbev_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [2:0]                        cfg_idx_i,
  input  wire logic [lbev_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  wire logic [1:0]                        in_op_i,
  input  wire logic signed [lbev_pkg::POS_W-1:0] in_x_i,
  input  wire logic signed [lbev_pkg::POS_W-1:0] in_y_i,
  input  wire logic signed [lbev_pkg::POS_W-1:0] in_z_i,
  input  wire logic [lbev_pkg::IDX_W-1:0]        in_row_i,
  input  wire logic [lbev_pkg::IDX_W-1:0]        in_col_i,
  input  wire lbev_pkg::cmd_t                    cmd_i,
  output lbev_pkg::sts_t                         sts_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic                                   out_written_o,
  output logic [lbev_pkg::IDX_W-1:0]             out_row_o,
  output logic [lbev_pkg::IDX_W-1:0]             out_col_o,
  output logic [lbev_pkg::PIX_W-1:0]             out_value_o
);

  localparam int SW     = lbev_pkg::SIDE_W;
  localparam int AW     = lbev_pkg::ADDR_W;
  localparam int CELL_W = lbev_pkg::CELL_W;

  // configuration
  logic signed [15:0] cos_q, sin_q, hlow_q, hhigh_q;
  logic [15:0]        rad_q, cpm_q;
  logic [7:0]         smax_q, smin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= 16'sd32767;
      sin_q   <= 16'sd0;
      rad_q   <= 16'd12800;
      cpm_q   <= 16'd1024;
      hlow_q  <= -16'sd768;
      hhigh_q <= 16'sd768;
      smax_q  <= 8'd255;
      smin_q  <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (lbev_pkg::cfg_idx_e'(cfg_idx_i))
        lbev_pkg::CFG_COS:    cos_q   <= cfg_wdata_i;
        lbev_pkg::CFG_SIN:    sin_q   <= cfg_wdata_i;
        lbev_pkg::CFG_RADIUS: rad_q   <= cfg_wdata_i;
        lbev_pkg::CFG_CPM:    cpm_q   <= cfg_wdata_i;
        lbev_pkg::CFG_HLOW:   hlow_q  <= cfg_wdata_i;
        lbev_pkg::CFG_HHIGH:  hhigh_q <= cfg_wdata_i;
        lbev_pkg::CFG_SMAX:   smax_q  <= cfg_wdata_i[7:0];
        lbev_pkg::CFG_SMIN:   smin_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // captured beat
  logic [1:0]                        op_q;
  logic signed [lbev_pkg::POS_W-1:0] x_q, y_q, z_q;
  logic [lbev_pkg::IDX_W-1:0]        rrow_q, rcol_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_op_i;
      x_q    <= in_x_i;
      y_q    <= in_y_i;
      z_q    <= in_z_i;
      rrow_q <= in_row_i;
      rcol_q <= in_col_i;
    end
  end

  // stage 1: window test, rotation products, side, shade operands
  logic signed [24:0] xe, ye, ze, re, hle, hhe;
  logic               pass_d;
  logic signed [16:0] xs, ys, zs;
  logic signed [32:0] sy, cx, sx, cy;
  logic signed [34:0] off, prow_d, pcol_d;
  logic [31:0]        rc_prod;
  logic [16:0]        side17;
  logic [SW-1:0]      side_d;
  logic signed [16:0] dd, lo;
  logic signed [17:0] zz;
  logic signed [8:0]  sdiff;
  logic signed [26:0] nn;

  always_comb begin
    xe     = 25'(x_q);
    ye     = 25'(y_q);
    ze     = 25'(z_q);
    re     = $signed({9'd0, rad_q});
    hle    = 25'(hlow_q);
    hhe    = 25'(hhigh_q);
    pass_d = (xe >= -re) && (xe <= re) && (ye >= -re) && (ye <= re) &&
             (ze >= hle) && (ze <= hhe);
    xs     = x_q[16:0];
    ys     = y_q[16:0];
    zs     = z_q[16:0];
    sy     = sin_q * ys;
    cx     = cos_q * xs;
    sx     = sin_q * xs;
    cy     = cos_q * ys;
    off    = $signed({4'd0, rad_q, 15'd0});
    prow_d = 35'(sy) - 35'(cx) + off;
    pcol_d = -35'(sx) - 35'(cy) + off;
    rc_prod = rad_q * cpm_q;
    side17  = {rc_prod[31:16], 1'b0};
    side_d  = (side17 > 17'(lbev_pkg::MAX_SIDE)) ? SW'(lbev_pkg::MAX_SIDE) : SW'(side17);
    dd     = 17'(hhigh_q) - 17'(hlow_q);
    lo     = hlow_q[15] ? -17'(hlow_q) : 17'(hlow_q);
    zz     = 18'(zs) + 18'(lo);
    sdiff  = $signed({1'b0, smax_q}) - $signed({1'b0, smin_q});
    nn     = sdiff * zz;
  end

  logic               pass_q;
  logic signed [34:0] prow_q, pcol_q;
  logic [SW-1:0]      side_q;
  logic signed [16:0] d_q;
  logic signed [26:0] n_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      pass_q <= pass_d;
      prow_q <= prow_d;
      pcol_q <= pcol_d;
      side_q <= side_d;
      d_q    <= dd;
      n_q    <= nn;
    end
  end

  // stage 2: scale to cells, shade numerator and range flags
  logic signed [51:0] vrow_d, vcol_d;
  logic signed [28:0] num_d, den256;
  logic signed [51:0] vrow_q, vcol_q;
  logic [27:0]        num_q;
  logic [16:0]        den_q;
  logic               zero_q, sat_q;

  always_comb begin
    vrow_d = prow_q * $signed({1'b0, cpm_q});
    vcol_d = pcol_q * $signed({1'b0, cpm_q});
    num_d  = (29'(n_q) <<< 1) + 29'(d_q);
    den256 = 29'(d_q) <<< 9;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      vrow_q <= vrow_d;
      vcol_q <= vcol_d;
      num_q  <= num_d[27:0];
      den_q  <= {d_q[15:0], 1'b0};
      zero_q <= (d_q <= 17'sd0) || (n_q <= 27'sd0);
      sat_q  <= num_d >= den256;
    end
  end

  // stage 3: round to cell, bounds check, divider setup
  logic signed [51:0] trow, tcol;
  logic [CELL_W-1:0]  crow, ccol;
  logic               hit_d;
  logic               hit_q;
  logic [SW-1:0]      crow_q, ccol_q;
  logic [27:0]        rem_q;
  logic [23:0]        dsh_q;
  logic [7:0]         quo_q;

  always_comb begin
    trow  = vrow_q + (52'sd1 <<< 30);
    tcol  = vcol_q + (52'sd1 <<< 30);
    crow  = trow[51:31];
    ccol  = tcol[51:31];
    hit_d = pass_q && !trow[51] && !tcol[51] &&
            (crow < CELL_W'(side_q)) && (ccol < CELL_W'(side_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.check) begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      crow_q <= crow[SW-1:0];
      ccol_q <= ccol[SW-1:0];
      rem_q  <= num_q;
      dsh_q  <= {den_q, 7'd0};
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= 28'(dsh_q)) begin
        rem_q <= rem_q - 28'(dsh_q);
        quo_q <= {quo_q[6:0], 1'b1};
      end else begin
        quo_q <= {quo_q[6:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  logic [7:0] shade;
  assign shade = zero_q ? 8'd0 : (sat_q ? 8'd255 : quo_q);

  // image memory
  logic [7:0]    mem_q [lbev_pkg::DEPTH];
  logic [AW-1:0] clr_cnt_q, wr_addr, rd_addr;
  logic          we;
  logic [7:0]    wdata, rd_q;
  logic          rd_in;

  assign rd_in   = (32'(rrow_q) < 32'(lbev_pkg::MAX_SIDE)) &&
                   (32'(rcol_q) < 32'(lbev_pkg::MAX_SIDE));
  assign rd_addr = AW'(rrow_q) * AW'(lbev_pkg::MAX_SIDE) + AW'(rcol_q);
  assign we      = cmd_i.wr || cmd_i.clr_step;
  assign wdata   = cmd_i.wr ? shade : 8'd0;
  assign wr_addr = cmd_i.wr ? (AW'(crow_q) * AW'(lbev_pkg::MAX_SIDE) + AW'(ccol_q))
                            : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_addr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd && rd_in) rd_q <= mem_q[rd_addr];
  end

  // result register
  logic                       ov_q;
  logic                       ow_q;
  logic [lbev_pkg::IDX_W-1:0] orow_q, ocol_q;
  logic [7:0]                 oval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ow_q   <= 1'b0;
      orow_q <= '0;
      ocol_q <= '0;
      oval_q <= '0;
      case (op_q)
        lbev_pkg::OP_POINT: begin
          if (hit_q) begin
            ow_q   <= 1'b1;
            orow_q <= lbev_pkg::IDX_W'(crow_q);
            ocol_q <= lbev_pkg::IDX_W'(ccol_q);
            oval_q <= shade;
          end
        end
        lbev_pkg::OP_READ: begin
          orow_q <= rrow_q;
          ocol_q <= rcol_q;
          oval_q <= rd_in ? rd_q : 8'd0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = ov_q;
  assign out_written_o = ow_q;
  assign out_row_o     = orow_q;
  assign out_col_o     = ocol_q;
  assign out_value_o   = oval_q;

  assign sts_o.hit          = hit_q;
  assign sts_o.shade_direct = zero_q || sat_q;
  assign sts_o.clr_last     = (clr_cnt_q == AW'(lbev_pkg::DEPTH - 1));
  assign sts_o.out_free     = !ov_q || out_ready_i;

  a_write_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |-> hit_q)
    else $error("pixel write without a hit");

  a_div_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> !(zero_q || sat_q))
    else $error("divide step on a saturated or zero shade");

endmodule

`default_nettype wire

FILE: rtl/lidar_point_to_bev_raster_top.sv
// Top level of the lidar bird's-eye height rasterizer.
// Depends on lbev_pkg, lbev_if, lbev_ctrl and lbev_dp.
`timescale 1ns / 1ps
`default_nettype none

// One operation per input beat, one result beat per operation. A projected
// point passes two multiply stages, a rounding/bounds stage, a restoring
// divide for the shade, the pixel write and the result load; the divide is
// skipped when the shade is zero or saturated, and a rejected point skips
// the divide and the write. A pixel read goes through a read state and the
// result load. Clearing writes one pixel per cycle through the single write
// port, so a clear operation sweeps all MAX_SIDE*MAX_SIDE pixels. After
// reset the same sweep runs before the first beat is accepted; configuration
// writes are taken at any time.
// A finished result waits in an output register while the next beat is taken.
module lidar_point_to_bev_raster_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [2:0]                 cfg_idx_i,
  input  wire logic [lbev_pkg::CFG_W-1:0] cfg_wdata_i,
  lbev_in_if.sink                         point_i,
  lbev_out_if.source                      result_o
);

  lbev_pkg::cmd_t cmd;
  lbev_pkg::sts_t sts;
  logic           in_ready;

  assign point_i.ready = in_ready;

  lbev_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (point_i.valid),
    .in_op_i    (point_i.operation),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lbev_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_op_i       (point_i.operation),
    .in_x_i        (point_i.pos_x),
    .in_y_i        (point_i.pos_y),
    .in_z_i        (point_i.pos_z),
    .in_row_i      (point_i.read_row),
    .in_col_i      (point_i.read_col),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (result_o.valid),
    .out_written_o (result_o.pixel_written),
    .out_row_o     (result_o.out_row),
    .out_col_o     (result_o.out_col),
    .out_value_o   (result_o.pixel_value)
  );

endmodule

`default_nettype wire

FILE: tb/lbev_result_checker.sv
// Scoreboard for the bird's-eye rasterizer: snoops the config port and both
// streams, predicts each result beat and compares it. Depends on lbev_pkg, lbev_if.
`timescale 1ns / 1ps

module lbev_result_checker (
  input  logic                       clk_i,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [lbev_pkg::CFG_W-1:0] cfg_wdata_i,
  lbev_in_if                         point_i,
  lbev_out_if                        result_o,
  output int                         fail_count_o,
  output int                         pending_o
);
  import lbev_pkg::*;

  typedef struct packed {
    logic             written;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [PIX_W-1:0] value;
  } raster_beat_t;

  logic signed [15:0] cos_q, sin_q, hlow_q, hhigh_q;
  logic [15:0]        radius_q, cpm_q;
  logic [7:0]         smax_q, smin_q;
  logic [PIX_W-1:0]   height_img [DEPTH];
  raster_beat_t       expected_q [$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  initial begin
    cos_q = 16'sd32767; sin_q = 16'sd0; radius_q = 16'd12800; cpm_q = 16'd1024;
    hlow_q = -16'sd768; hhigh_q = 16'sd768; smax_q = 8'd255; smin_q = 8'd0;
    fails = 0;
    foreach (height_img[i]) height_img[i] = '0;
  end

  function automatic logic [PIX_W-1:0] shade(longint z);
    longint d, lo, n, q;
    d  = longint'(hhigh_q) - longint'(hlow_q);
    lo = (hlow_q < 0) ? -longint'(hlow_q) : longint'(hlow_q);
    n  = (longint'(smax_q) - longint'(smin_q)) * (z + lo);
    if (d <= 0 || n <= 0) return '0;
    q = (2 * n + d) / (2 * d);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic raster_beat_t rasterize(logic [1:0] op, longint x, longint y, longint z,
                                             logic [IDX_W-1:0] rr, logic [IDX_W-1:0] rc);
    raster_beat_t b;
    longint c, s, rad, cpm, side, tr, tc;
    b   = '0;
    c   = cos_q;
    s   = sin_q;
    rad = radius_q;
    cpm = cpm_q;
    if (op == OP_CLEAR) begin
      foreach (height_img[i]) height_img[i] = '0;
    end else if (op == OP_POINT) begin
      side = 2 * ((rad * cpm) >>> 16);
      if (side > MAX_SIDE) side = MAX_SIDE;
      if (x < -rad || x > rad || y < -rad || y > rad || z < hlow_q || z > hhigh_q) return b;
      tr = (s * y - c * x + rad * 32768) * cpm + (longint'(1) << 30);
      tc = (-s * x - c * y + rad * 32768) * cpm + (longint'(1) << 30);
      if (tr < 0 || tc < 0) return b;
      tr = tr >>> 31;
      tc = tc >>> 31;
      if (tr >= side || tc >= side) return b;
      b.written = 1'b1;
      b.row     = tr[IDX_W-1:0];
      b.col     = tc[IDX_W-1:0];
      b.value   = shade(z);
      height_img[tr * MAX_SIDE + tc] = b.value;
    end else if (op == OP_READ) begin
      b.row   = rr;
      b.col   = rc;
      b.value = height_img[int'(rr) * MAX_SIDE + int'(rc)];
    end
    return b;
  endfunction

  always @(posedge clk_i) begin
    raster_beat_t got, want;
    if (result_o.valid && result_o.ready) begin
      got = '{result_o.pixel_written, result_o.out_row, result_o.out_col,
              result_o.pixel_value};
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: unexpected result beat w=%0d r=%0d c=%0d v=%0d", $realtime,
                   got.written, got.row, got.col, got.value);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10)
            $display("%0t: mismatch exp w=%0d r=%0d c=%0d v=%0d got w=%0d r=%0d c=%0d v=%0d",
                     $realtime, want.written, want.row, want.col, want.value,
                     got.written, got.row, got.col, got.value);
        end
      end
    end
    // predict with the config in force at the accepting edge, then apply writes
    if (point_i.valid && point_i.ready)
      expected_q.push_back(rasterize(point_i.operation, longint'(point_i.pos_x),
                                     longint'(point_i.pos_y), longint'(point_i.pos_z),
                                     point_i.read_row, point_i.read_col));
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COS:    cos_q    <= cfg_wdata_i;
        CFG_SIN:    sin_q    <= cfg_wdata_i;
        CFG_RADIUS: radius_q <= cfg_wdata_i;
        CFG_CPM:    cpm_q    <= cfg_wdata_i;
        CFG_HLOW:   hlow_q   <= cfg_wdata_i;
        CFG_HHIGH:  hhigh_q  <= cfg_wdata_i;
        CFG_SMAX:   smax_q   <= cfg_wdata_i[7:0];
        CFG_SMIN:   smin_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: tb/lidar_point_to_bev_raster_top_test.sv
// Testbench top for the bird's-eye rasterizer: clock, reset, config phases,
// point/read/clear stimulus and verdict. Depends on lbev_pkg, lbev_if, lbev_result_checker.
`timescale 1ns / 1ps

module lidar_point_to_bev_raster_top_test;
  import lbev_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 5_000_000;

  logic             clk_i, rst_ni, cfg_we_i;
  logic [2:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  int               fail_count, pending, cycles;
  int               send_idle_pct, recv_stall_pct;
  logic [IDX_W-1:0] hit_rows [$], hit_cols [$];

  // aiming copies of the config used to keep most points inside the filters
  int aim_radius, aim_hlow, aim_hhigh;

  lbev_in_if  point_if ();
  lbev_out_if result_if ();

  lidar_point_to_bev_raster_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .point_i(point_if.sink), .result_o(result_if.source)
  );

  lbev_result_checker u_checker (
    .clk_i(clk_i), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .point_i(point_if), .result_o(result_if), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (result_if.valid && result_if.ready && result_if.pixel_written
        && hit_rows.size() < 64) begin
      hit_rows.push_back(result_if.out_row);
      hit_cols.push_back(result_if.out_col);
    end
  end

  task automatic send(logic [1:0] op, int x, int y, int z, int rr, int rc);
    while ($urandom_range(99) < send_idle_pct) begin
      point_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    point_if.valid     <= 1'b1;
    point_if.operation <= op;
    point_if.pos_x     <= x[POS_W-1:0];
    point_if.pos_y     <= y[POS_W-1:0];
    point_if.pos_z     <= z[POS_W-1:0];
    point_if.read_row  <= rr[IDX_W-1:0];
    point_if.read_col  <= rc[IDX_W-1:0];
    do @(posedge clk_i); while (!point_if.ready);
  endtask

  // sender holds off until every result is back, then lets the block settle
  task automatic drain();
    point_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    if (idx == CFG_RADIUS) aim_radius = val & 16'hFFFF;
    if (idx == CFG_HLOW)   aim_hlow   = $signed(val[15:0]);
    if (idx == CFG_HHIGH)  aim_hhigh  = $signed(val[15:0]);
  endtask

  task automatic apply_setting(int sel);
    int v [8];
    case (sel)
      0: v = '{32767, 0, 12800, 1024, -768, 768, 255, 0};
      1: v = '{-32768, 0, 65535, 65535, -32768, 32767, 255, 0};
      2: v = '{23170, 23170, 3200, 4096, -32768, 32767, 200, 10};
      3: v = '{0, -32768, 300, 65535, 100, 100, 0, 255};
      4: v = '{32767, 32767, 12800, 1024, 0, 1, 255, 0};
      5: v = '{-23170, 32767, 1, 65535, -200, 300, 10, 200};
      6: v = '{0, 32767, 65535, 1, -768, 768, 255, 255};
      default: begin
        v = '{$urandom_range(65535), $urandom_range(65535), $urandom_range(65535, 1),
              $urandom_range(65535, 1), -$urandom_range(2000), $urandom_range(2000),
              $urandom_range(255), $urandom_range(255)};
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_e'(i), v[i]);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_item(bit allow_clear);
    int pick, x, y, z, k;
    pick = $urandom_range(99);
    if (allow_clear && pick == 0) begin
      send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 12) begin
      if (hit_rows.size() > 0 && $urandom_range(3) != 0) begin
        k = $urandom_range(hit_rows.size() - 1);
        send(OP_READ, $urandom, $urandom, $urandom, hit_rows[k], hit_cols[k]);
      end else begin
        send(OP_READ, $urandom, $urandom, $urandom, $urandom_range(511), $urandom_range(511));
      end
    end else if (pick < 15) begin
      send(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 25) begin
      send(OP_POINT, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      x = $urandom_range(2 * aim_radius) - aim_radius;
      y = $urandom_range(2 * aim_radius) - aim_radius;
      if (aim_hhigh >= aim_hlow) z = aim_hlow + $urandom_range(aim_hhigh - aim_hlow);
      else z = $urandom_range(1000) - 500;
      send(OP_POINT, x, y, z, $urandom, $urandom);
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    aim_radius = 12800; aim_hlow = -768; aim_hhigh = 768;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    point_if.valid = 1'b0; point_if.operation = OP_CLEAR;
    point_if.pos_x = '0; point_if.pos_y = '0; point_if.pos_z = '0;
    point_if.read_row = '0; point_if.read_col = '0;
    result_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults first
    send(OP_POINT, 0, 0, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 200, 200);
    send(OP_POINT, 12800, 12800, 768, 511, 511);
    send(OP_POINT, -12800, -12800, -768, 0, 0);
    send(OP_POINT, 12801, 0, 0, 0, 0);
    send(OP_POINT, 0, -12801, 0, 0, 0);
    send(OP_POINT, 0, 0, 769, 0, 0);
    send(OP_POINT, 0, 0, -769, 0, 0);
    send(OP_POINT, 8388607, -8388608, 8388607, 0, 0);
    send(OP_POINT, -8388608, 8388607, -8388608, 0, 0);
    send(OP_POINT, 32, 32, 100, 0, 0);
    send(OP_READ, 0, 0, 0, 511, 511);
    send(OP_READ, -1, -1, -1, 0, 0);
    send(OP_UNUSED, -1, -1, -1, 511, 511);
    send(OP_CLEAR, 0, 0, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 200, 200);
    drain();
    // equal height bounds and a negative shade difference
    apply_setting(3);
    send(OP_POINT, 100, 100, 100, 0, 0);
    send(OP_POINT, -300, 300, 100, 0, 0);
    drain();
    apply_setting(5);
    send(OP_POINT, 0, 0, 300, 0, 0);
    send(OP_POINT, 1, -1, -200, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      apply_setting(ph == 7 ? 7 : (ph + 1) % 7);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int n = 0; n < 80; n++) random_item(ph == 4 && n == 40);
      drain();
      // one more pass at the defaults with the sender idling
      if (ph == 5) begin
        apply_setting(0);
        for (int n = 0; n < 20; n++) random_item(1'b0);
        drain();
      end
    end

    recv_stall_pct = 0;
    repeat (30) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lbev_pkg.sv
rtl/lbev_if.sv
rtl/lbev_ctrl.sv
rtl/lbev_dp.sv
rtl/lidar_point_to_bev_raster_top.sv
tb/lbev_result_checker.sv
tb/lidar_point_to_bev_raster_top_test.sv
